// ===== src/mws_pkg.sv =====
package mws_pkg;

   localparam int PIX_W      = 8;
   localparam int THR_W      = 8;
   localparam int RADCFG_W   = 2;
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_RADIUS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   // register reset values
   localparam logic [THR_W-1:0]    RST_THRESHOLD    = 8'd5;
   localparam logic [RADCFG_W-1:0] RST_WIN_RADIUS   = 2'd2;
   localparam logic [FW_W-1:0]     RST_FRAME_WIDTH  = 11'd640;
   localparam logic [FH_W-1:0]     RST_FRAME_HEIGHT = 12'd480;

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] S_READ  = 3'd1;
   localparam logic [ST_W-1:0] S_SCAN  = 3'd2;
   localparam logic [ST_W-1:0] S_DIVGO = 3'd3;
   localparam logic [ST_W-1:0] S_DIV   = 3'd4;
   localparam logic [ST_W-1:0] S_OUT   = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/mws_ram.sv =====
module mws_ram import mws_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mws_cell.sv =====
module mws_cell import mws_pkg::*; #(
   parameter int WIN = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  logic [WIN-1:0][PIX_W-1:0] col_in,
   output logic [WIN-1:0][PIX_W-1:0] col_out
);

   logic [WIN-1:0][PIX_W-1:0] col_ff;

   // one window column, taken from the neighbor on each shift
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== src/mws_column_sum.sv =====
module mws_column_sum import mws_pkg::*; #(
   parameter int WIN = 5
) (
   input  logic [WIN-1:0][PIX_W-1:0]        col,
   input  logic [PIX_W-1:0]                 centre,
   input  logic [THR_W-1:0]                 threshold,
   input  logic [$clog2(WIN)-1:0]           lo,
   input  logic [$clog2(WIN)-1:0]           hi,
   output logic [PIX_W+$clog2(WIN+1)-1:0]   sum,
   output logic [$clog2(WIN+1)-1:0]         cnt
);

   localparam int CS_W = PIX_W + $clog2(WIN + 1);
   localparam int CC_W = $clog2(WIN + 1);

   // masked sum of the rows inside the radius
   always_comb begin
      logic [PIX_W-1:0] diff;
      sum = '0;
      cnt = '0;
      for (int y = 0; y < WIN; y++) begin
         diff = (col[y] > centre) ? (col[y] - centre) : (centre - col[y]);
         if (32'(y) >= 32'(lo) && 32'(y) <= 32'(hi) && diff <= threshold) begin
            sum = sum + CS_W'(col[y]);
            cnt = cnt + CC_W'(1);
         end
      end
   end

endmodule

// ===== src/mws_divider.sv =====
module mws_divider import mws_pkg::*; #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_status_type   status,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] work_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             take;

   assign trial = {rem_ff[DEN_W-1:0], work_ff[NUM_W-1]};
   assign take  = (trial >= {1'b0, den_ff});

   // control: one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // restoring shift and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= num;
         den_ff  <= den;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= take ? (trial - {1'b0, den_ff}) : trial;
         work_ff <= {work_ff[NUM_W-2:0], take};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = work_ff;

endmodule

// ===== src/masked_window_soften.sv =====
// an accepted item goes through the line store access and, once the window is filled, the scan,
//   the divider start, the divide (one quotient bit per sum bit, plus done) and the output
// a new item is taken only in the idle state, after the last one is done; results can stall
// a pixel leaves MAX_RADIUS*width+MAX_RADIUS items after it entered
// reset: synchronous, clears counters, window cells and registers to their defaults;
//   line stores are not cleared
module masked_window_soften import mws_pkg::*; #(
   parameter int MAX_RADIUS = 2,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_frame_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MR    = MAX_RADIUS;
   localparam int WIN   = 2 * MR + 1;
   localparam int LINES = 2 * MR;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int DLY_W = $clog2(MR * MAX_WIDTH + MR + 2);
   localparam int PND_W = DLY_W + 1;
   localparam int IDX_W = $clog2(WIN);
   localparam int CYC_W = $clog2(WIN + 1);
   localparam int CS_W  = PIX_W + $clog2(WIN + 1);
   localparam int CC_W  = $clog2(WIN + 1);
   localparam int SUM_W = PIX_W + $clog2(WIN * WIN + 1);
   localparam int CNT_W = $clog2(WIN * WIN + 1);

   // configuration registers
   logic [THR_W-1:0]    thr_ff;
   logic [RADCFG_W-1:0] rad_ff;
   logic [FW_W-1:0]     fw_ff;
   logic [FH_W-1:0]     fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= RST_THRESHOLD;
         rad_ff <= RST_WIN_RADIUS;
         fw_ff  <= RST_FRAME_WIDTH;
         fh_ff  <= RST_FRAME_HEIGHT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD:    thr_ff <= csr_wdata[THR_W-1:0];
            CSR_WIN_RADIUS:   rad_ff <= csr_wdata[RADCFG_W-1:0];
            CSR_FRAME_WIDTH:  fw_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff  <= csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [WID_W-1:0] eff_w;
   logic [FH_W-1:0]  eff_h;
   logic [IDX_W-1:0] eff_r;
   logic [IDX_W-1:0] lo;
   logic [IDX_W-1:0] hi;
   logic [DLY_W-1:0] delay;

   always_comb begin
      if (fw_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(fw_ff);
      end
      eff_h = (fh_ff == '0) ? FH_W'(1) : fh_ff;
      if (rad_ff == '0) begin
         eff_r = IDX_W'(1);
      end else if (32'(rad_ff) > 32'(MR)) begin
         eff_r = IDX_W'(MR);
      end else begin
         eff_r = IDX_W'(rad_ff);
      end
      lo    = IDX_W'(MR) - eff_r;
      hi    = IDX_W'(MR) + eff_r;
      delay = DLY_W'(MR) * DLY_W'(eff_w) + DLY_W'(MR);
   end

   // raster advance, returns {row, column}
   function automatic logic [FH_W+COL_W-1:0] step_pos(
      input logic [COL_W-1:0] col,
      input logic [FH_W-1:0]  row,
      input logic [WID_W-1:0] w,
      input logic [FH_W-1:0]  h
   );
      logic [COL_W-1:0] nc;
      logic [FH_W-1:0]  nr;
      nc = col;
      nr = row;
      if (32'(col) + 1 >= 32'(w)) begin
         nc = '0;
         if (32'(row) + 1 >= 32'(h)) begin
            nr = '0;
         end else begin
            nr = row + FH_W'(1);
         end
      end else begin
         nc = col + COL_W'(1);
      end
      return {nr, nc};
   endfunction

   // control state
   logic [ST_W-1:0]  state_ff;
   logic [COL_W-1:0] in_col_ff, out_col_ff, base_col;
   logic [FH_W-1:0]  in_row_ff, out_row_ff, base_row;
   logic [DLY_W-1:0] filled_ff, filled_nx;
   logic [PND_W-1:0] pending_ff;
   logic [CYC_W-1:0] scan_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] centre_ff;
   logic [SUM_W-1:0] acc_sum_ff;
   logic [CNT_W-1:0] acc_cnt_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_last_ff;

   logic acc, work, restart, out_free, out_load, interior, last_pos;

   assign req_stall = (state_ff != S_IDLE);
   assign acc       = req_valid && !req_stall;
   assign work      = acc && (!req_func || pending_ff != '0);
   assign restart   = acc && !req_func && pending_ff == '0;
   assign base_col  = restart ? out_col_ff : in_col_ff;
   assign base_row  = restart ? out_row_ff : in_row_ff;
   assign filled_nx = (filled_ff <= delay) ? filled_ff + DLY_W'(1) : filled_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == S_OUT) && out_free;

   assign interior = 32'(out_row_ff) >= 32'(eff_r) && 32'(out_row_ff) + 32'(eff_r) < 32'(eff_h)
                  && 32'(out_col_ff) >= 32'(eff_r)
                  && 32'(out_col_ff) + 32'(eff_r) < 32'(eff_w);
   assign last_pos = 32'(out_row_ff) == 32'(eff_h) - 1 && 32'(out_col_ff) == 32'(eff_w) - 1;

   // line stores
   logic [LINES-1:0][PIX_W-1:0] line_rd;
   logic [LINES-1:0][PIX_W-1:0] line_wr;
   logic                        line_we;

   assign line_we = (state_ff == S_READ);

   for (genvar k = 0; k < LINES; k++) begin : g_line
      if (k < LINES - 1) begin : g_mid
         assign line_wr[k] = line_rd[k+1];
      end else begin : g_top
         assign line_wr[k] = pix_ff;
      end
      mws_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
         .clock   (clock),
         .wr_en   (line_we),
         .wr_addr (in_col_ff),
         .wr_data (line_wr[k]),
         .rd_addr (base_col),
         .rd_data (line_rd[k])
      );
   end

   // window as a chain of column cells, rotated during the scan
   logic [WIN-1:0][WIN-1:0][PIX_W-1:0] cols;
   logic [WIN-1:0][PIX_W-1:0]          new_col;
   logic [WIN-1:0][PIX_W-1:0]          tail_in;
   logic                               cell_shift;

   always_comb begin
      for (int y = 0; y < LINES; y++) begin
         new_col[y] = line_rd[y];
      end
      new_col[LINES] = pix_ff;
   end

   assign tail_in    = (state_ff == S_READ) ? new_col : cols[0];
   assign cell_shift = (state_ff == S_READ) || (state_ff == S_SCAN);

   for (genvar c = 0; c < WIN; c++) begin : g_cell
      mws_cell #(.WIN(WIN)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (cell_shift),
         .col_in   ((c == WIN - 1) ? tail_in : cols[(c + 1) % WIN]),
         .col_out  (cols[c])
      );
   end

   // masked sum of the column at the head of the chain
   logic [CS_W-1:0] col_sum;
   logic [CC_W-1:0] col_cnt;

   mws_column_sum #(.WIN(WIN)) u_colsum (
      .col       (cols[0]),
      .centre    (centre_ff),
      .threshold (thr_ff),
      .lo        (lo),
      .hi        (hi),
      .sum       (col_sum),
      .cnt       (col_cnt)
   );

   // rounded quotient
   div_status_type   div_st;
   logic [SUM_W-1:0] quot;
   logic [SUM_W-1:0] numer;

   assign numer = acc_sum_ff + SUM_W'(acc_cnt_ff >> 1) - SUM_W'(1);

   mws_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == S_DIVGO),
      .num    (numer),
      .den    (acc_cnt_ff),
      .status (div_st),
      .quot   (quot)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         filled_ff  <= '0;
         pending_ff <= '0;
         scan_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (work) begin
                  in_col_ff <= base_col;
                  in_row_ff <= base_row;
                  if (restart) begin
                     filled_ff <= '0;
                  end
                  if (!req_func) begin
                     pending_ff <= pending_ff + PND_W'(1);
                  end
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               filled_ff <= filled_nx;
               {in_row_ff, in_col_ff} <= step_pos(in_col_ff, in_row_ff, eff_w, eff_h);
               scan_ff <= '0;
               state_ff <= (filled_nx > delay) ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
               scan_ff <= scan_ff + CYC_W'(1);
               if (scan_ff == CYC_W'(WIN - 1)) begin
                  state_ff <= S_DIVGO;
               end
            end
            S_DIVGO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_st.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  {out_row_ff, out_col_ff} <= step_pos(out_col_ff, out_row_ff, eff_w, eff_h);
                  pending_ff <= pending_ff - PND_W'(1);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // item data path
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && work) begin
         pix_ff <= req_func ? '0 : req_pixel_in;
      end
      if (state_ff == S_READ) begin
         centre_ff  <= cols[MR+1][MR];
         acc_sum_ff <= '0;
         acc_cnt_ff <= '0;
      end
      if (state_ff == S_SCAN && 32'(scan_ff) >= 32'(lo) && 32'(scan_ff) <= 32'(hi)) begin
         acc_sum_ff <= acc_sum_ff + SUM_W'(col_sum);
         acc_cnt_ff <= acc_cnt_ff + CNT_W'(col_cnt);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff <= (interior && acc_cnt_ff > CNT_W'(1)) ? quot[PIX_W-1:0] : centre_ff;
         rsp_last_ff  <= last_pos;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef ASSERT_OFF
   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      out_load |-> pending_ff != '0)
      else $error("result emitted with nothing pending");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_read_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> (state_ff == S_IDLE || state_ff == S_SCAN))
      else $error("bad state after line store access");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
   import mws_pkg::*;

   localparam int RADIUS_MAX  = 2;
   localparam int WIDTH_MAX   = 1024;
   localparam int WIN_SIDE    = 2 * RADIUS_MAX + 1;
   localparam int LINE_COUNT  = 2 * RADIUS_MAX;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 60;
   localparam int LONG_HOLD   = 3000;
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct {
      logic             func;
      logic [PIX_W-1:0] pix;
   } luma_item_t;

   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             last;
   } soft_pixel_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_func = FUNC_PIXEL;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_last;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   luma_item_t  item_q[$];
   soft_pixel_t soft_q[$];

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned drains_sent = 0;
   int unsigned results_seen = 0;
   int unsigned phase_count = 0;
   bit          no_idle = 1'b0;
   bit          hold_start = 1'b0;
   bit          hold_used = 1'b0;
   int unsigned hold_cnt = 0;
   int unsigned send_gap = 0;
   int unsigned stall_cnt = 0;

   // smoothing predictor state
   logic [PIX_W-1:0] line_mem [0:LINE_COUNT*WIDTH_MAX-1];
   logic [PIX_W-1:0] win [0:WIN_SIDE-1][0:WIN_SIDE-1];
   int unsigned in_col, in_row, out_col, out_row, n_pending, n_filled;
   int unsigned m_thr, m_rad, m_w, m_h;

   masked_window_soften dut (.*);

   always #1 clock = ~clock;

   function automatic int unsigned eff_w();
      if (m_w == 0) return 1;
      if (m_w > WIDTH_MAX) return WIDTH_MAX;
      return m_w;
   endfunction

   function automatic int unsigned eff_h();
      return (m_h == 0) ? 1 : m_h;
   endfunction

   function automatic int unsigned eff_r();
      if (m_rad == 0) return 1;
      if (m_rad > RADIUS_MAX) return RADIUS_MAX;
      return m_rad;
   endfunction

   function automatic int unsigned delay_items();
      return RADIUS_MAX * eff_w() + RADIUS_MAX;
   endfunction

   function automatic void step_pos(inout int unsigned col, inout int unsigned row);
      col++;
      if (col >= eff_w()) begin
         col = 0;
         row++;
         if (row >= eff_h()) row = 0;
      end
   endfunction

   // shift one sample into the line stores and the window
   function automatic void shift_in(logic [PIX_W-1:0] pix);
      logic [PIX_W-1:0] v [0:WIN_SIDE-1];
      int unsigned c;
      c = (in_col >= WIDTH_MAX) ? WIDTH_MAX - 1 : in_col;
      for (int k = 0; k < LINE_COUNT; k++) v[k] = line_mem[k*WIDTH_MAX + c];
      v[LINE_COUNT] = pix;
      for (int k = 0; k < LINE_COUNT; k++) line_mem[k*WIDTH_MAX + c] = v[k+1];
      for (int rr = 0; rr < WIN_SIDE; rr++) begin
         for (int cc = 0; cc < WIN_SIDE - 1; cc++) win[rr][cc] = win[rr][cc+1];
         win[rr][WIN_SIDE-1] = v[rr];
      end
      if (n_filled <= delay_items()) n_filled++;
      step_pos(in_col, in_row);
   endfunction

   // selective average of the window centre, or a copy at the frame edge or when only the centre qualifies
   function automatic void soften_center();
      int unsigned r, w, h, centre, val, sum, count, p, d;
      soft_pixel_t res;
      r = eff_r();
      w = eff_w();
      h = eff_h();
      centre = win[RADIUS_MAX][RADIUS_MAX];
      val = centre;
      if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w) begin
         sum = 0;
         count = 0;
         for (int y = RADIUS_MAX - r; y <= RADIUS_MAX + r; y++)
            for (int x = RADIUS_MAX - r; x <= RADIUS_MAX + r; x++) begin
               p = win[y][x];
               d = (p > centre) ? p - centre : centre - p;
               if (d <= m_thr) begin
                  sum += p;
                  count++;
               end
            end
         if (count > 1) val = (sum + count / 2 - 1) / count;
      end
      res.pix = val[PIX_W-1:0];
      res.last = (out_row == h - 1 && out_col == w - 1);
      soft_q.push_back(res);
      step_pos(out_col, out_row);
      if (n_pending > 0) n_pending--;
   endfunction

   // queue one item and predict what it produces
   function automatic void send_item(logic func, logic [PIX_W-1:0] pix);
      luma_item_t it;
      it.func = func;
      it.pix = pix;
      item_q.push_back(it);
      if (func == FUNC_PIXEL) begin
         pixels_sent++;
         if (n_pending == 0) begin
            in_col = out_col;
            in_row = out_row;
            n_filled = 0;
         end
         shift_in(pix);
         n_pending++;
      end else begin
         drains_sent++;
         if (n_pending == 0) return;
         shift_in('0);
      end
      if (n_filled > delay_items()) soften_center();
   endfunction

   function automatic void flush_pending();
      while (n_pending > 0) send_item(FUNC_DRAIN, PIX_W'($urandom));
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PIX_W-1:0] textured(int unsigned base, int unsigned spread);
      int v;
      if ($urandom_range(0, 99) < 15) return PIX_W'($urandom);
      v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[PIX_W-1:0];
   endfunction

   task automatic wait_idle();
      while (item_q.size() != 0 || req_valid || soft_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_THRESHOLD:    m_thr = value & 8'hFF;
         CSR_WIN_RADIUS:   m_rad = value & 2'h3;
         CSR_FRAME_WIDTH:  m_w = value & 11'h7FF;
         CSR_FRAME_HEIGHT: m_h = value & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic setup(int unsigned thr, int unsigned rad, int unsigned w, int unsigned h);
      wait_idle();
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_WIN_RADIUS, rad);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      phase_count++;
   endtask

   // stimulus and configuration sequence
   initial begin
      int unsigned w, h, npix, base, spread, rand_pixels;
      for (int i = 0; i < LINE_COUNT * WIDTH_MAX; i++) line_mem[i] = '0;
      for (int y = 0; y < WIN_SIDE; y++)
         for (int x = 0; x < WIN_SIDE; x++) win[y][x] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      n_pending = 0; n_filled = 0;
      m_thr = RST_THRESHOLD;
      m_rad = RST_WIN_RADIUS;
      m_w = RST_FRAME_WIDTH;
      m_h = RST_FRAME_HEIGHT;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: widest threshold, small radius, extreme samples
      setup(255, 1, 5, 5);
      send_item(FUNC_DRAIN, 8'hFF);
      for (int i = 0; i < 25; i++) send_item(FUNC_PIXEL, (i % 3 == 0) ? 8'hFF : 8'h00);
      flush_pending();

      // directed: zero threshold, full radius, isolated centres
      setup(0, 2, 6, 5);
      for (int i = 0; i < 30; i++) send_item(FUNC_PIXEL, (i == 14) ? 8'h80 : 8'h7F);
      send_item(FUNC_DRAIN, 8'h00);
      for (int i = 0; i < 6; i++) send_item(FUNC_PIXEL, 8'hFF);
      flush_pending();

      // receiver holds off long while the sender keeps going
      setup(20, 2, 16, 16);
      no_idle = 1'b1;
      hold_start = 1'b1;
      for (int i = 0; i < 256; i++) send_item(FUNC_PIXEL, textured(100, 25));
      flush_pending();
      wait_idle();
      no_idle = 1'b0;

      // wide line
      setup(12, 1, 64, 2);
      for (int i = 0; i < 128; i++) send_item(FUNC_PIXEL, textured(60, 10));
      flush_pending();

      // tallest frame, out of range radius codes
      setup(128, 3, 1, 4095);
      for (int i = 0; i < 40; i++) send_item(FUNC_PIXEL, PIX_W'($urandom));
      flush_pending();
      setup(7, 0, 0, 0);
      for (int i = 0; i < 10; i++) send_item(FUNC_PIXEL, PIX_W'($urandom));
      flush_pending();

      // random frames
      rand_pixels = 0;
      while (rand_pixels < 300) begin
         w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
         h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0: setup(0, $urandom_range(0, 3), w, h);
            1: setup(255, $urandom_range(0, 3), w, h);
            default: setup($urandom_range(0, 40), $urandom_range(0, 3), w, h);
         endcase
         no_idle = ($urandom_range(0, 4) == 0);
         npix = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
         npix = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * npix) : npix;
         if (npix > 150) npix = 150;
         base = $urandom_range(0, 255);
         spread = $urandom_range(0, 40);
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 99) < 4) send_item(FUNC_DRAIN, PIX_W'($urandom));
            send_item(FUNC_PIXEL, textured(base, spread));
         end
         rand_pixels += npix;
         if ($urandom_range(0, 3) == 0) begin
            // drain fully, then resume the same frame
            flush_pending();
            for (int i = 0; i < 8; i++) send_item(FUNC_PIXEL, textured(base, spread));
         end
         flush_pending();
      end

      wait_idle();
      $display("covered %0d phases: %0d pixel items, %0d drain items, %0d results checked",
               phase_count, pixels_sent, drains_sent, results_seen);
      $display("radius codes 0..3, widths up to 64, heights up to 4095, long output hold");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         if (item_q.size() != 0 && (no_idle || $urandom_range(0, 99) < 70)) begin
            req_func <= item_q[0].func;
            req_pixel_in <= item_q[0].pix;
            void'(item_q.pop_front());
         end else begin
            req_valid <= 1'b0;
            send_gap <= no_idle ? 0 : pick_gap();
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (item_q.size() != 0) begin
            req_valid <= 1'b1;
            req_func <= item_q[0].func;
            req_pixel_in <= item_q[0].pix;
            void'(item_q.pop_front());
         end
      end
   end

   // output monitor and stall generator
   always @(posedge clock) begin
      soft_pixel_t want;
      int unsigned errs;
      errs = 0;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (soft_q.size() == 0) begin
            $error("result with nothing expected: pixel_out %0d", rsp_pixel_out);
            errs++;
         end else begin
            want = soft_q.pop_front();
            if (rsp_pixel_out !== want.pix) begin
               $error("pixel_out expected %0d actual %0d", want.pix, rsp_pixel_out);
               errs++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last expected %0d actual %0d", want.last, rsp_frame_last);
               errs++;
            end
         end
      end
      if (errs != 0) begin
         fail_count <= fail_count + errs;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_start && !hold_used) begin
         hold_used <= 1'b1;
         hold_cnt <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= (hold_cnt > 1);
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_stall <= (stall_cnt > 1);
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_cnt <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
